[rtl/core/oledcp_pkg.sv]
// oledcp_pkg: shared types, command codes and reset values for the display
// command parser and display-ram writer. No dependencies.
package oledcp_pkg;

    localparam int COLUMNS_DEF   = 128;
    localparam int RAM_BYTES_DEF = 1024;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
    localparam int LIN_W         = 17;

    localparam logic [7:0] CMD_ADDR_MODE  = 8'h20;
    localparam logic [7:0] CMD_COL_RANGE  = 8'h21;
    localparam logic [7:0] CMD_PAGE_RANGE = 8'h22;
    localparam logic [7:0] CMD_CONTRAST   = 8'h81;
    localparam logic [7:0] CMD_PAGE_LO    = 8'hB0;
    localparam logic [7:0] CMD_PAGE_HI    = 8'hB7;
    localparam logic [7:0] CMD_CHARGE     = 8'h8D;
    localparam logic [7:0] CMD_MUX        = 8'hA8;
    localparam logic [7:0] CMD_OFFSET     = 8'hD3;
    localparam logic [7:0] CMD_CLKDIV     = 8'hD5;
    localparam logic [7:0] CMD_PRECHARGE  = 8'hD9;
    localparam logic [7:0] CMD_PINS       = 8'hDA;
    localparam logic [7:0] CMD_VCOM       = 8'hDB;
    localparam logic [7:0] CMD_NONE       = 8'h00;
    localparam logic [3:0] NIB_COL_LO     = 4'h0;
    localparam logic [3:0] NIB_COL_HI     = 4'h1;

    localparam logic [1:0] MODE_HORIZ = 2'd0;
    localparam logic [1:0] MODE_VERT  = 2'd1;
    localparam logic [1:0] MODE_PAGE  = 2'd2;
    localparam logic [1:0] MODE_OFF   = 2'd3;

    localparam logic [1:0] ARGS_NONE = 2'd0;
    localparam logic [1:0] ARGS_ONE  = 2'd1;
    localparam logic [1:0] ARGS_TWO  = 2'd2;

    localparam logic [7:0] COL_LIMIT_RST = 8'd127;
    localparam logic [7:0] PAGE_LIMIT_RST = 8'd7;
    localparam logic [7:0] CONTRAST_RST  = 8'd127;

    localparam int CTRL_MODE_BIT = 6;

    typedef enum logic [1:0] {
        KIND_READ,
        KIND_CTRL,
        KIND_DATA,
        KIND_CMD
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        last;
        logic [7:0]  byte_value;
        logic [9:0]  read_addr;
    } t_item;

endpackage

[rtl/core/oled_command_parser_gddram_writer_top.sv]
// oled_command_parser_gddram_writer_top: display command parser and display-ram
// writer. An input beat is registered in the queue and then in the result register;
// one beat per cycle sustained while the result side takes results and no clear runs.
// After reset the ram is cleared one byte a cycle, and no input beat is taken
// during that pass. Depends on oledcp_pkg, oledcp_front, oledcp_queue and
// oledcp_back.
module oled_command_parser_gddram_writer_top #(
    parameter int COLUMNS   = oledcp_pkg::COLUMNS_DEF,
    parameter int RAM_BYTES = oledcp_pkg::RAM_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic        i_first,
    input  logic        i_last,
    input  logic [7:0]  i_byte_value,
    input  logic [9:0]  i_read_addr,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic        o_ram_written,
    output logic [9:0]  o_wr_addr,
    output logic [7:0]  o_ram_data,
    output logic [1:0]  o_mode_now,
    output logic [7:0]  o_contrast_now
);

    oledcp_pkg::t_item front_item, back_item;
    logic front_valid, q_ready, q_valid, back_ready, busy;

    oledcp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_op         (i_op),
        .i_first      (i_first),
        .i_last       (i_last),
        .i_byte_value (i_byte_value),
        .i_read_addr  (i_read_addr),
        .i_q_ready    (q_ready),
        .i_busy       (busy),
        .o_item_valid (front_valid),
        .o_item       (front_item)
    );

    oledcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (q_ready),
        .i_item  (front_item),
        .o_valid (q_valid),
        .i_ready (back_ready),
        .o_item  (back_item)
    );

    oledcp_back #(
        .COLUMNS   (COLUMNS),
        .RAM_BYTES (RAM_BYTES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (q_valid),
        .o_item_ready   (back_ready),
        .i_item         (back_item),
        .o_busy         (busy),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_read_data    (o_read_data),
        .o_ram_written  (o_ram_written),
        .o_wr_addr      (o_wr_addr),
        .o_ram_data     (o_ram_data),
        .o_mode_now     (o_mode_now),
        .o_contrast_now (o_contrast_now)
    );

endmodule

[rtl/core/oledcp_front.sv]
// oledcp_front: accepts bus beats and classifies them as read, control, data or
// command, tracking the data/command mode. Depends on oledcp_pkg.
module oledcp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_op,
    input  logic                i_first,
    input  logic                i_last,
    input  logic [7:0]          i_byte_value,
    input  logic [9:0]          i_read_addr,
    input  logic                i_q_ready,
    input  logic                i_busy,
    output logic                o_item_valid,
    output oledcp_pkg::t_item   o_item
);

    logic r_data_mode;
    logic n_data_mode;
    logic accept;

    assign o_ready      = i_q_ready && !i_busy;
    assign o_item_valid = i_valid && !i_busy;
    assign accept       = i_valid && o_ready;

    always_comb begin
        o_item.last       = i_last;
        o_item.byte_value = i_byte_value;
        o_item.read_addr  = i_read_addr;
        if (i_op) begin
            o_item.kind = oledcp_pkg::KIND_READ;
        end else if (i_first) begin
            o_item.kind = oledcp_pkg::KIND_CTRL;
        end else if (r_data_mode) begin
            o_item.kind = oledcp_pkg::KIND_DATA;
        end else begin
            o_item.kind = oledcp_pkg::KIND_CMD;
        end
    end

    always_comb begin
        n_data_mode = r_data_mode;
        if (accept && !i_op && i_first) begin
            n_data_mode = i_byte_value[oledcp_pkg::CTRL_MODE_BIT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_mode <= 1'b0;
        end else begin
            r_data_mode <= n_data_mode;
        end
    end

endmodule

[rtl/core/oledcp_queue.sv]
// oledcp_queue: short register fifo of classified beats between front and back.
// Depends on oledcp_pkg.
module oledcp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  oledcp_pkg::t_item   i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output oledcp_pkg::t_item   o_item
);

    localparam int DEPTH = oledcp_pkg::QUEUE_DEPTH;
    localparam int AW    = oledcp_pkg::QUEUE_AW;

    oledcp_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]     r_wptr, n_wptr;
    logic [AW-1:0]     r_rptr, n_rptr;
    logic [AW:0]       r_count, n_count;
    logic              push, pop;

    assign o_ready = (r_count < (AW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wptr  = push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

[rtl/core/oledcp_back.sv]
// oledcp_back: command parser state, pointer advance, display ram with its
// clearing pass, and the result register. Depends on oledcp_pkg.
module oledcp_back #(
    parameter int COLUMNS   = oledcp_pkg::COLUMNS_DEF,
    parameter int RAM_BYTES = oledcp_pkg::RAM_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    output logic                o_item_ready,
    input  oledcp_pkg::t_item   i_item,
    output logic                o_busy,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_read_data,
    output logic                o_ram_written,
    output logic [9:0]          o_wr_addr,
    output logic [7:0]          o_ram_data,
    output logic [1:0]          o_mode_now,
    output logic [7:0]          o_contrast_now
);

    localparam int AW = (RAM_BYTES > 1) ? $clog2(RAM_BYTES) : 1;
    localparam int LW = oledcp_pkg::LIN_W;

    logic [7:0]    r_ram [RAM_BYTES];
    logic [7:0]    r_rd_q;
    logic          r_busy;
    logic [AW-1:0] r_clr_addr;

    logic [1:0] r_mode, n_mode;
    logic [7:0] r_col, n_col;
    logic [7:0] r_col_lim, n_col_lim;
    logic [7:0] r_page, n_page;
    logic [7:0] r_page_lim, n_page_lim;
    logic [7:0] r_contrast, n_contrast;
    logic [7:0] r_pend, n_pend;
    logic [1:0] r_args, n_args;
    logic [7:0] r_farg, n_farg;

    logic       r_out_valid;
    logic       r_o_rd_ok;
    logic       r_o_wr;
    logic [9:0] r_o_waddr;
    logic [7:0] r_o_wdata;

    logic          fire;
    logic [7:0]    b;
    logic          is_last;
    logic [LW-1:0] lin;
    logic          stored;
    logic          do_start;
    logic          pend_range;
    logic [7:0]    c1, p1;
    logic [15:0]   ra_ext;
    logic          rd_ok;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;

    assign fire         = i_item_valid && !r_busy && (!r_out_valid || i_ready);
    assign o_item_ready = !r_busy && (!r_out_valid || i_ready);
    assign o_busy       = r_busy;
    assign b            = i_item.byte_value;
    assign is_last      = i_item.last;
    assign lin          = LW'(r_page) * LW'(COLUMNS) + LW'(r_col);
    assign stored       = (r_mode != oledcp_pkg::MODE_OFF) && (lin < LW'(RAM_BYTES));
    assign ra_ext       = 16'(i_item.read_addr);
    assign rd_ok        = (ra_ext < 16'(RAM_BYTES));
    assign c1           = r_col + 8'd1;
    assign p1           = r_page + 8'd1;
    assign pend_range   = (r_pend == oledcp_pkg::CMD_COL_RANGE)
                       || (r_pend == oledcp_pkg::CMD_PAGE_RANGE);
    assign do_start     = (r_args == oledcp_pkg::ARGS_NONE)
                       || (pend_range && r_args == oledcp_pkg::ARGS_TWO && is_last);

    always_comb begin
        n_mode     = r_mode;
        n_col      = r_col;
        n_col_lim  = r_col_lim;
        n_page     = r_page;
        n_page_lim = r_page_lim;
        n_contrast = r_contrast;
        n_pend     = r_pend;
        n_args     = r_args;
        n_farg     = r_farg;
        if (fire) begin
            case (i_item.kind)
                oledcp_pkg::KIND_CTRL: begin
                    n_pend = oledcp_pkg::CMD_NONE;
                    n_args = oledcp_pkg::ARGS_NONE;
                end
                oledcp_pkg::KIND_DATA: begin
                    if (r_mode == oledcp_pkg::MODE_VERT) begin
                        if (p1 > r_page_lim) begin
                            n_page = '0;
                            n_col  = (c1 > r_col_lim) ? 8'd0 : c1;
                        end else begin
                            n_page = p1;
                        end
                    end else if (r_mode != oledcp_pkg::MODE_OFF) begin
                        if (c1 > r_col_lim) begin
                            n_col = '0;
                            if (r_mode == oledcp_pkg::MODE_HORIZ) begin
                                n_page = (p1 > r_page_lim) ? 8'd0 : p1;
                            end
                        end else begin
                            n_col = c1;
                        end
                    end
                end
                oledcp_pkg::KIND_CMD: begin
                    if (do_start) begin
                        if (b == oledcp_pkg::CMD_ADDR_MODE || b == oledcp_pkg::CMD_CONTRAST
                            || b inside {oledcp_pkg::CMD_CHARGE, oledcp_pkg::CMD_MUX,
                                         oledcp_pkg::CMD_OFFSET, oledcp_pkg::CMD_CLKDIV,
                                         oledcp_pkg::CMD_PRECHARGE, oledcp_pkg::CMD_PINS,
                                         oledcp_pkg::CMD_VCOM}) begin
                            n_pend = b;
                            n_args = oledcp_pkg::ARGS_ONE;
                        end else if (b == oledcp_pkg::CMD_COL_RANGE
                                     || b == oledcp_pkg::CMD_PAGE_RANGE) begin
                            n_pend = b;
                            n_args = oledcp_pkg::ARGS_TWO;
                        end else if (b inside {[oledcp_pkg::CMD_PAGE_LO:
                                                oledcp_pkg::CMD_PAGE_HI]}) begin
                            n_page = {5'd0, b[2:0]};
                        end else if (b[7:4] == oledcp_pkg::NIB_COL_LO) begin
                            n_col = {r_col[7:4], b[3:0]};
                        end else if (b[7:4] == oledcp_pkg::NIB_COL_HI) begin
                            n_col = {b[3:0], r_col[3:0]};
                        end
                    end else if (pend_range && r_args == oledcp_pkg::ARGS_TWO) begin
                        n_farg = b;
                        n_args = oledcp_pkg::ARGS_ONE;
                    end else begin
                        case (r_pend)
                            oledcp_pkg::CMD_COL_RANGE: begin
                                n_col     = r_farg;
                                n_col_lim = b;
                            end
                            oledcp_pkg::CMD_PAGE_RANGE: begin
                                n_page     = r_farg;
                                n_page_lim = b;
                            end
                            oledcp_pkg::CMD_ADDR_MODE: begin
                                n_mode = b[1:0];
                            end
                            oledcp_pkg::CMD_CONTRAST: begin
                                n_contrast = b;
                            end
                            default: begin
                            end
                        endcase
                        n_pend = oledcp_pkg::CMD_NONE;
                        n_args = oledcp_pkg::ARGS_NONE;
                    end
                end
                default: begin
                end
            endcase
            if (i_item.kind != oledcp_pkg::KIND_READ && is_last) begin
                n_pend = oledcp_pkg::CMD_NONE;
                n_args = oledcp_pkg::ARGS_NONE;
            end
        end
    end

    always_comb begin
        we    = r_busy || (fire && i_item.kind == oledcp_pkg::KIND_DATA && stored);
        waddr = r_busy ? r_clr_addr : lin[AW-1:0];
        wdata = r_busy ? 8'd0 : b;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_ram[waddr] <= wdata;
        end
        if (fire && i_item.kind == oledcp_pkg::KIND_READ) begin
            r_rd_q <= r_ram[ra_ext[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_o_rd_ok <= (i_item.kind == oledcp_pkg::KIND_READ) && rd_ok;
            r_o_wr    <= (i_item.kind == oledcp_pkg::KIND_DATA) && stored;
            r_o_waddr <= ((i_item.kind == oledcp_pkg::KIND_DATA) && stored) ? lin[9:0] : 10'd0;
            r_o_wdata <= ((i_item.kind == oledcp_pkg::KIND_DATA) && stored) ? b : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b1;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_mode      <= oledcp_pkg::MODE_PAGE;
            r_col       <= '0;
            r_col_lim   <= oledcp_pkg::COL_LIMIT_RST;
            r_page      <= '0;
            r_page_lim  <= oledcp_pkg::PAGE_LIMIT_RST;
            r_contrast  <= oledcp_pkg::CONTRAST_RST;
            r_pend      <= oledcp_pkg::CMD_NONE;
            r_args      <= oledcp_pkg::ARGS_NONE;
            r_farg      <= '0;
        end else begin
            if (r_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(RAM_BYTES - 1)) begin
                    r_busy <= 1'b0;
                end
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            r_mode     <= n_mode;
            r_col      <= n_col;
            r_col_lim  <= n_col_lim;
            r_page     <= n_page;
            r_page_lim <= n_page_lim;
            r_contrast <= n_contrast;
            r_pend     <= n_pend;
            r_args     <= n_args;
            r_farg     <= n_farg;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_read_data    = r_o_rd_ok ? r_rd_q : 8'd0;
    assign o_ram_written  = r_o_wr;
    assign o_wr_addr      = r_o_waddr;
    assign o_ram_data     = r_o_wdata;
    assign o_mode_now     = r_mode;
    assign o_contrast_now = r_contrast;

endmodule

[test/oled_command_parser_gddram_writer_top_tb.sv]
`timescale 1ns / 100ps
// testbench for oled_command_parser_gddram_writer_top: bus write beats and ram reads under
// random stalls on both channels, checked against a behavioral mirror of the parser state
// depends on oledcp_pkg and the rtl top level
module oled_command_parser_gddram_writer_top_tb;

    localparam bit OP_BUS_BYTE = 1'b0;
    localparam bit OP_RAM_READ = 1'b1;
    localparam int TOTAL_BEATS = 950;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS = 10;
    localparam logic [7:0] SKIP_CMDS [7] = '{oledcp_pkg::CMD_CHARGE, oledcp_pkg::CMD_MUX,
                                             oledcp_pkg::CMD_OFFSET, oledcp_pkg::CMD_CLKDIV,
                                             oledcp_pkg::CMD_PRECHARGE, oledcp_pkg::CMD_PINS,
                                             oledcp_pkg::CMD_VCOM};

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BLOCK} t_stall;

    typedef struct packed {
        logic [7:0] read_data;
        logic       ram_written;
        logic [9:0] wr_addr;
        logic [7:0] ram_data;
        logic [1:0] mode_now;
        logic [7:0] contrast_now;
    } t_result;

    class parser_mirror;
        logic [7:0] pixel_ram [oledcp_pkg::RAM_BYTES_DEF];
        logic [1:0] addr_mode;
        logic [7:0] col_ptr, col_lim, page_ptr, page_lim, contrast, held_cmd, first_arg;
        logic [1:0] args_left;
        logic       data_mode;
        logic [9:0] last_pixel_addr;
        t_result    due_results[$];
        int         mismatches;

        function new();
            foreach (pixel_ram[i]) pixel_ram[i] = 8'h00;
            addr_mode = oledcp_pkg::MODE_PAGE;
            col_ptr = 8'd0;
            col_lim = oledcp_pkg::COL_LIMIT_RST;
            page_ptr = 8'd0;
            page_lim = oledcp_pkg::PAGE_LIMIT_RST;
            contrast = oledcp_pkg::CONTRAST_RST;
            held_cmd = oledcp_pkg::CMD_NONE;
            first_arg = 8'd0;
            args_left = oledcp_pkg::ARGS_NONE;
            data_mode = 1'b0;
            last_pixel_addr = 10'd0;
            mismatches = 0;
        endfunction

        function void open_command(logic [7:0] c, bit is_last);
            if (c == oledcp_pkg::CMD_ADDR_MODE || c == oledcp_pkg::CMD_CONTRAST
                    || c inside {oledcp_pkg::CMD_CHARGE, oledcp_pkg::CMD_MUX,
                                 oledcp_pkg::CMD_OFFSET, oledcp_pkg::CMD_CLKDIV,
                                 oledcp_pkg::CMD_PRECHARGE, oledcp_pkg::CMD_PINS,
                                 oledcp_pkg::CMD_VCOM}) begin
                if (!is_last) begin
                    held_cmd = c;
                    args_left = oledcp_pkg::ARGS_ONE;
                end
            end else if (c == oledcp_pkg::CMD_COL_RANGE || c == oledcp_pkg::CMD_PAGE_RANGE) begin
                if (!is_last) begin
                    held_cmd = c;
                    args_left = oledcp_pkg::ARGS_TWO;
                end
            end else if (c >= oledcp_pkg::CMD_PAGE_LO && c <= oledcp_pkg::CMD_PAGE_HI) begin
                page_ptr = {5'd0, c[2:0]};
            end else if (c[7:4] == oledcp_pkg::NIB_COL_LO) begin
                col_ptr[3:0] = c[3:0];
            end else if (c[7:4] == oledcp_pkg::NIB_COL_HI) begin
                col_ptr[7:4] = c[3:0];
            end
        endfunction

        function void command_beat(logic [7:0] b, bit is_last);
            if (args_left == oledcp_pkg::ARGS_NONE) begin
                open_command(b, is_last);
                return;
            end
            if ((held_cmd == oledcp_pkg::CMD_COL_RANGE || held_cmd == oledcp_pkg::CMD_PAGE_RANGE)
                    && args_left == oledcp_pkg::ARGS_TWO) begin
                if (is_last) begin
                    // lone first argument goes back through the command decode
                    held_cmd = oledcp_pkg::CMD_NONE;
                    args_left = oledcp_pkg::ARGS_NONE;
                    open_command(b, 1'b1);
                end else begin
                    first_arg = b;
                    args_left = oledcp_pkg::ARGS_ONE;
                end
                return;
            end
            case (held_cmd)
                oledcp_pkg::CMD_COL_RANGE: begin
                    col_ptr = first_arg;
                    col_lim = b;
                end
                oledcp_pkg::CMD_PAGE_RANGE: begin
                    page_ptr = first_arg;
                    page_lim = b;
                end
                oledcp_pkg::CMD_ADDR_MODE: addr_mode = b[1:0];
                oledcp_pkg::CMD_CONTRAST: contrast = b;
                default: ;
            endcase
            held_cmd = oledcp_pkg::CMD_NONE;
            args_left = oledcp_pkg::ARGS_NONE;
        endfunction

        function void store_pixel(logic [7:0] b, inout t_result res);
            int lin;
            if (addr_mode == oledcp_pkg::MODE_OFF) return;
            lin = int'(page_ptr) * oledcp_pkg::COLUMNS_DEF + int'(col_ptr);
            if (lin < oledcp_pkg::RAM_BYTES_DEF) begin
                pixel_ram[lin] = b;
                res.ram_written = 1'b1;
                res.wr_addr = lin[9:0];
                res.ram_data = b;
                last_pixel_addr = lin[9:0];
            end
            // pointers wrap at 8 bits before the limit compare
            if (addr_mode == oledcp_pkg::MODE_VERT) begin
                page_ptr = page_ptr + 8'd1;
                if (page_ptr > page_lim) begin
                    page_ptr = 8'd0;
                    col_ptr = col_ptr + 8'd1;
                    if (col_ptr > col_lim) col_ptr = 8'd0;
                end
            end else begin
                col_ptr = col_ptr + 8'd1;
                if (col_ptr > col_lim) begin
                    col_ptr = 8'd0;
                    if (addr_mode == oledcp_pkg::MODE_HORIZ) begin
                        page_ptr = page_ptr + 8'd1;
                        if (page_ptr > page_lim) page_ptr = 8'd0;
                    end
                end
            end
        endfunction

        function void absorb_beat(bit op, bit is_first, bit is_last, logic [7:0] b,
                                  logic [9:0] ra);
            t_result res;
            res = '0;
            if (op == OP_RAM_READ) begin
                if (int'(ra) < oledcp_pkg::RAM_BYTES_DEF) res.read_data = pixel_ram[ra];
            end else if (is_first) begin
                data_mode = b[oledcp_pkg::CTRL_MODE_BIT];
                held_cmd = oledcp_pkg::CMD_NONE;
                args_left = oledcp_pkg::ARGS_NONE;
            end else if (data_mode) begin
                store_pixel(b, res);
            end else begin
                command_beat(b, is_last);
            end
            if (op == OP_BUS_BYTE && is_last) begin
                held_cmd = oledcp_pkg::CMD_NONE;
                args_left = oledcp_pkg::ARGS_NONE;
            end
            res.mode_now = addr_mode;
            res.contrast_now = contrast;
            due_results.push_back(res);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat: rd=%h wr=%b addr=%0d data=%h mode=%0d con=%h",
                             got.read_data, got.ram_written, got.wr_addr, got.ram_data,
                             got.mode_now, got.contrast_now);
                return;
            end
            want = due_results.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("mismatch expected: rd=%h wr=%b addr=%0d data=%h mode=%0d con=%h",
                             want.read_data, want.ram_written, want.wr_addr, want.ram_data,
                             want.mode_now, want.contrast_now);
                    $display("         actual:   rd=%h wr=%b addr=%0d data=%h mode=%0d con=%h",
                             got.read_data, got.ram_written, got.wr_addr, got.ram_data,
                             got.mode_now, got.contrast_now);
                end
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic       i_op;
    logic       i_first;
    logic       i_last;
    logic [7:0] i_byte_value;
    logic [9:0] i_read_addr;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_read_data;
    logic       o_ram_written;
    logic [9:0] o_wr_addr;
    logic [7:0] o_ram_data;
    logic [1:0] o_mode_now;
    logic [7:0] o_contrast_now;

    parser_mirror mirror = new();
    logic [7:0]   txn_bytes[$];
    int           beats_sent = 0;
    int           burst_left = 0;

    oled_command_parser_gddram_writer_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_first        (i_first),
        .i_last         (i_last),
        .i_byte_value   (i_byte_value),
        .i_read_addr    (i_read_addr),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_read_data    (o_read_data),
        .o_ram_written  (o_ram_written),
        .o_wr_addr      (o_wr_addr),
        .o_ram_data     (o_ram_data),
        .o_mode_now     (o_mode_now),
        .o_contrast_now (o_contrast_now)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("oled_command_parser_gddram_writer_top verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            mirror.check_result(t_result'({o_read_data, o_ram_written, o_wr_addr, o_ram_data,
                                           o_mode_now, o_contrast_now}));
    end

    // result side stalls in phases of its own
    initial begin
        t_stall style;
        int     phase_len;
        i_out_ready = 1'b0;
        forever begin
            style = t_stall'($urandom_range(0, 3));
            phase_len = (style == STALL_BLOCK) ? $urandom_range(1, 8) : $urandom_range(4, 40);
            repeat (phase_len) begin
                @(negedge i_clk);
                case (style)
                    STALL_NONE:  i_out_ready <= 1'b1;
                    STALL_LIGHT: i_out_ready <= ($urandom_range(0, 3) != 0);
                    STALL_HEAVY: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default:     i_out_ready <= 1'b0;
                endcase
            end
        end
    end

    task automatic send_beat(input bit op, input bit is_first, input bit is_last,
                             input logic [7:0] bval, input logic [9:0] ra);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_op <= op;
        i_first <= is_first;
        i_last <= is_last;
        i_byte_value <= bval;
        i_read_addr <= ra;
        do @(posedge i_clk); while (!o_in_ready);
        mirror.absorb_beat(op, is_first, is_last, bval, ra);
        beats_sent++;
    endtask

    task automatic bus_beat(input bit is_first, input bit is_last, input logic [7:0] bval);
        send_beat(OP_BUS_BYTE, is_first, is_last, bval, 10'($urandom));
    endtask

    task automatic ram_read(input logic [9:0] ra);
        send_beat(OP_RAM_READ, 1'($urandom), 1'($urandom), 8'($urandom), ra);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (mirror.due_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic void queue_command();
        logic [7:0] lo, hi;
        case ($urandom_range(0, 8))
            0: begin
                txn_bytes.push_back(oledcp_pkg::CMD_ADDR_MODE);
                lo = 8'($urandom);
                lo[1:0] = ($urandom_range(0, 7) == 0) ? oledcp_pkg::MODE_OFF
                                                      : 2'($urandom_range(0, 2));
                txn_bytes.push_back(lo);
            end
            1, 2: begin
                txn_bytes.push_back(($urandom_range(0, 1) == 0) ? oledcp_pkg::CMD_COL_RANGE
                                                                : oledcp_pkg::CMD_PAGE_RANGE);
                if ($urandom_range(0, 5) == 0) begin
                    lo = 8'($urandom);
                    hi = 8'($urandom);
                end else if (txn_bytes[txn_bytes.size() - 1] == oledcp_pkg::CMD_COL_RANGE) begin
                    lo = 8'($urandom_range(0, 127));
                    hi = 8'($urandom_range(lo, 127));
                end else begin
                    lo = 8'($urandom_range(0, 7));
                    hi = 8'($urandom_range(lo, 7));
                end
                txn_bytes.push_back(lo);
                txn_bytes.push_back(hi);
            end
            3: begin
                txn_bytes.push_back(oledcp_pkg::CMD_CONTRAST);
                txn_bytes.push_back(8'($urandom));
            end
            4: txn_bytes.push_back(oledcp_pkg::CMD_PAGE_LO + 8'($urandom_range(0, 7)));
            5: txn_bytes.push_back({oledcp_pkg::NIB_COL_LO, 4'($urandom)});
            6: txn_bytes.push_back({oledcp_pkg::NIB_COL_HI, ($urandom_range(0, 3) == 0) ?
                                    4'($urandom) : 4'($urandom_range(0, 7))});
            7: begin
                txn_bytes.push_back(SKIP_CMDS[$urandom_range(0, 6)]);
                txn_bytes.push_back(8'($urandom));
            end
            default: txn_bytes.push_back(8'($urandom));
        endcase
    endfunction

    task automatic random_transaction();
        int         kind, n;
        bit         closes;
        logic [7:0] ctrl;
        txn_bytes.delete();
        kind = $urandom_range(0, 9);
        if (kind >= 8) begin
            // noise: loose beats with arbitrary framing bits
            repeat ($urandom_range(1, 6))
                bus_beat(($urandom_range(0, 5) == 0), ($urandom_range(0, 4) == 0), 8'($urandom));
            return;
        end
        ctrl = 8'($urandom);
        ctrl[oledcp_pkg::CTRL_MODE_BIT] = (kind >= 4);
        txn_bytes.push_back(ctrl);
        if (kind < 4) begin
            repeat ($urandom_range(1, 4)) queue_command();
            if ($urandom_range(0, 5) == 0)
                n = $urandom_range(1, txn_bytes.size());
            else
                n = txn_bytes.size();
            while (txn_bytes.size() > n) void'(txn_bytes.pop_back());
        end else begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 140) : $urandom_range(1, 24);
            repeat (n) txn_bytes.push_back(8'($urandom));
        end
        closes = ($urandom_range(0, 9) != 0);
        foreach (txn_bytes[i]) begin
            if ($urandom_range(0, 9) == 0)
                ram_read(($urandom_range(0, 1) == 0) ? mirror.last_pixel_addr : 10'($urandom));
            bus_beat(i == 0, closes && i == txn_bytes.size() - 1, txn_bytes[i]);
        end
    endtask

    initial begin
        bit mid_drained;
        mid_drained = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_op = OP_BUS_BYTE;
        i_first = 1'b0;
        i_last = 1'b0;
        i_byte_value = 8'h00;
        i_read_addr = 10'd0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        ram_read(10'd1023);
        bus_beat(1'b1, 1'b0, 8'h00);
        bus_beat(1'b0, 1'b0, oledcp_pkg::CMD_CONTRAST);
        bus_beat(1'b0, 1'b0, 8'hFF);
        bus_beat(1'b0, 1'b0, oledcp_pkg::CMD_ADDR_MODE);
        bus_beat(1'b0, 1'b0, {6'd0, oledcp_pkg::MODE_HORIZ});
        bus_beat(1'b0, 1'b0, oledcp_pkg::CMD_COL_RANGE);
        bus_beat(1'b0, 1'b0, 8'h7E);
        bus_beat(1'b0, 1'b0, 8'h7F);
        bus_beat(1'b0, 1'b1, oledcp_pkg::CMD_PAGE_HI);
        // pixels at the top of ram, then wrap of both pointers
        bus_beat(1'b1, 1'b0, 8'hC0);
        bus_beat(1'b0, 1'b0, 8'hFF);
        bus_beat(1'b0, 1'b1, 8'hA5);
        bus_beat(1'b0, 1'b0, 8'h5A);
        bus_beat(1'b1, 1'b1, 8'h00);
        bus_beat(1'b0, 1'b0, {oledcp_pkg::NIB_COL_HI, 4'hF});
        bus_beat(1'b0, 1'b0, oledcp_pkg::CMD_COL_RANGE);
        bus_beat(1'b0, 1'b1, oledcp_pkg::CMD_PAGE_HI);
        // write address past the end of ram
        bus_beat(1'b1, 1'b0, 8'h40);
        bus_beat(1'b0, 1'b0, 8'h33);
        bus_beat(1'b1, 1'b0, 8'h00);
        bus_beat(1'b0, 1'b0, oledcp_pkg::CMD_PRECHARGE);
        bus_beat(1'b0, 1'b0, 8'h55);
        bus_beat(1'b0, 1'b0, oledcp_pkg::CMD_ADDR_MODE);
        bus_beat(1'b0, 1'b0, {6'd0, oledcp_pkg::MODE_OFF});
        bus_beat(1'b0, 1'b1, oledcp_pkg::CMD_CONTRAST);
        bus_beat(1'b1, 1'b0, 8'h40);
        bus_beat(1'b0, 1'b1, 8'h12);
        ram_read(10'd1022);
        drain_results();

        while (beats_sent < TOTAL_BEATS) begin
            random_transaction();
            if (!mid_drained && beats_sent > TOTAL_BEATS / 2) begin
                drain_results();
                mid_drained = 1'b1;
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (mirror.due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mirror.mismatches == 0 && mirror.due_results.size() == 0)
            $display("oled_command_parser_gddram_writer_top verification clean");
        else
            $display("oled_command_parser_gddram_writer_top verification failed");
        $finish;
    end

endmodule
